>>> hdl/bmb_pkg.sv
// ----------------------------------------------------------------------------
// bmb_pkg
// shared constants for the box difference splitter: register map, margin
// width and the encoding of the six slab positions
// ----------------------------------------------------------------------------
package bmb_pkg;

  localparam int MARGIN_W  = 16;
  localparam int PADDR_W   = 3;
  localparam int PDATA_W   = 32;
  localparam int NUM_SLABS = 6;
  localparam int SLAB_IDX_W = 3;

  // register index, taken from paddr[2]
  localparam logic REG_OVERLAP_MARGIN = 1'b0;

  // slab order: x low, x high, y low, y high, z low, z high
  typedef logic [NUM_SLABS-1:0] slab_mask_t;

  localparam slab_mask_t SLAB_FIRST = slab_mask_t'(1);

endpackage

>>> hdl/box_minus_box_splitter_core.sv
// ----------------------------------------------------------------------------
// box_minus_box_splitter_core
// splits box A minus box B into up to six disjoint boxes, one beat each
// ----------------------------------------------------------------------------
// A pair of boxes is taken on every cycle in which in_stall is low. The pair
// passes a capture stage, a compare stage (margin overlap test, intersection,
// slab flags) and a piece emitter, then the output register, which shows the
// pieces. The emitter sends one piece per cycle while out_stall is low and
// keeps a pair until its last piece is loaded into the output register; only
// then does the next pair enter it. Pairs giving one piece each flow at one
// per cycle, and pairs giving more pieces hold back the earlier stages. The
// last piece of a pair carries out_last_piece; when B covers A and the margin
// overlap test passes, a single beat with out_nothing_left and zero corners is sent.
// ----------------------------------------------------------------------------
module box_minus_box_splitter_core #(
  parameter int COORD_BITS = 32
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // configuration
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [bmb_pkg::PADDR_W-1:0]      paddr,
  input  logic [bmb_pkg::PDATA_W-1:0]      pwdata,
  output logic [bmb_pkg::PDATA_W-1:0]      prdata,
  output logic                             pready,
  // input pairs
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic signed [COORD_BITS-1:0]     in_a_lo_x,
  input  logic signed [COORD_BITS-1:0]     in_a_lo_y,
  input  logic signed [COORD_BITS-1:0]     in_a_lo_z,
  input  logic signed [COORD_BITS-1:0]     in_a_hi_x,
  input  logic signed [COORD_BITS-1:0]     in_a_hi_y,
  input  logic signed [COORD_BITS-1:0]     in_a_hi_z,
  input  logic signed [COORD_BITS-1:0]     in_b_lo_x,
  input  logic signed [COORD_BITS-1:0]     in_b_lo_y,
  input  logic signed [COORD_BITS-1:0]     in_b_lo_z,
  input  logic signed [COORD_BITS-1:0]     in_b_hi_x,
  input  logic signed [COORD_BITS-1:0]     in_b_hi_y,
  input  logic signed [COORD_BITS-1:0]     in_b_hi_z,
  // result pieces
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic signed [COORD_BITS-1:0]     out_piece_lo_x,
  output logic signed [COORD_BITS-1:0]     out_piece_lo_y,
  output logic signed [COORD_BITS-1:0]     out_piece_lo_z,
  output logic signed [COORD_BITS-1:0]     out_piece_hi_x,
  output logic signed [COORD_BITS-1:0]     out_piece_hi_y,
  output logic signed [COORD_BITS-1:0]     out_piece_hi_z,
  output logic                             out_nothing_left,
  output logic                             out_last_piece
);
  import bmb_pkg::*;

  localparam int SUM_W = ((COORD_BITS > MARGIN_W) ? COORD_BITS : MARGIN_W) + 2;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [SUM_W-1:0]      sum_t;

  // configuration register
  logic [MARGIN_W-1:0] margin_r;
  logic                cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_OVERLAP_MARGIN);
  assign prdata = (paddr[2] == REG_OVERLAP_MARGIN) ? PDATA_W'(margin_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      margin_r <= '0;
    end else if (cfg_wr) begin
      margin_r <= pwdata[MARGIN_W-1:0];
    end
  end

  // pipeline handshake
  logic sa_v_r, sb_v_r, sc_v_r, out_valid_r;
  logic sa_v_nxt, sb_v_nxt, sc_v_nxt, out_valid_nxt;
  logic a_take, b_take, c_take, out_load, pick_last;

  // capture stage
  coord_t sa_alo_r [3];
  coord_t sa_ahi_r [3];
  coord_t sa_blo_r [3];
  coord_t sa_bhi_r [3];

  // compare stage
  coord_t     sb_alo_r [3];
  coord_t     sb_ahi_r [3];
  coord_t     sb_ilo_r [3];
  coord_t     sb_ihi_r [3];
  slab_mask_t sb_mask_r;
  logic       sb_whole_r, sb_empty_r;

  // emitter stage
  coord_t     sc_alo_r [3];
  coord_t     sc_ahi_r [3];
  coord_t     sc_ilo_r [3];
  coord_t     sc_ihi_r [3];
  slab_mask_t sc_mask_r, sc_mask_nxt;
  logic       sc_whole_r, sc_empty_r;

  assign c_take   = !sc_v_r || (out_load && pick_last);
  assign b_take   = !sb_v_r || c_take;
  assign a_take   = !sa_v_r || b_take;
  assign in_stall = !a_take;
  assign out_load = sc_v_r && (!out_valid_r || !out_stall);

  always_comb begin
    sa_v_nxt = a_take ? in_valid : sa_v_r;
    sb_v_nxt = b_take ? sa_v_r   : sb_v_r;
    sc_v_nxt = c_take ? sb_v_r   : sc_v_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sa_v_r      <= 1'b0;
      sb_v_r      <= 1'b0;
      sc_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      sa_v_r      <= sa_v_nxt;
      sb_v_r      <= sb_v_nxt;
      sc_v_r      <= sc_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // capture
  always_ff @(posedge clk) begin
    if (a_take) begin
      sa_alo_r[0] <= in_a_lo_x;
      sa_alo_r[1] <= in_a_lo_y;
      sa_alo_r[2] <= in_a_lo_z;
      sa_ahi_r[0] <= in_a_hi_x;
      sa_ahi_r[1] <= in_a_hi_y;
      sa_ahi_r[2] <= in_a_hi_z;
      sa_blo_r[0] <= in_b_lo_x;
      sa_blo_r[1] <= in_b_lo_y;
      sa_blo_r[2] <= in_b_lo_z;
      sa_bhi_r[0] <= in_b_hi_x;
      sa_bhi_r[1] <= in_b_hi_y;
      sa_bhi_r[2] <= in_b_hi_z;
    end
  end

  // overlap test, intersection and slab flags
  sum_t       margin_ext;
  logic       overlap;
  slab_mask_t slabs;
  slab_mask_t mask_nxt;
  coord_t     ilo_nxt [3];
  coord_t     ihi_nxt [3];

  always_comb begin
    sum_t alo_sum, blo_sum, ahi_ext, bhi_ext;
    margin_ext = sum_t'({1'b0, margin_r});
    overlap    = 1'b1;
    slabs      = '0;
    for (int d = 0; d < 3; d++) begin
      alo_sum = sum_t'(sa_alo_r[d]) + margin_ext;
      blo_sum = sum_t'(sa_blo_r[d]) + margin_ext;
      ahi_ext = sum_t'(sa_ahi_r[d]);
      bhi_ext = sum_t'(sa_bhi_r[d]);
      if ((alo_sum > bhi_ext) || (blo_sum > ahi_ext)) begin
        overlap = 1'b0;
      end
      ilo_nxt[d]     = (sa_alo_r[d] > sa_blo_r[d]) ? sa_alo_r[d] : sa_blo_r[d];
      ihi_nxt[d]     = (sa_ahi_r[d] < sa_bhi_r[d]) ? sa_ahi_r[d] : sa_bhi_r[d];
      slabs[2*d]     = sa_alo_r[d] < sa_blo_r[d];
      slabs[2*d + 1] = sa_ahi_r[d] > sa_bhi_r[d];
    end
    mask_nxt = (overlap && (slabs != '0)) ? slabs : SLAB_FIRST;
  end

  always_ff @(posedge clk) begin
    if (b_take) begin
      sb_alo_r   <= sa_alo_r;
      sb_ahi_r   <= sa_ahi_r;
      sb_ilo_r   <= ilo_nxt;
      sb_ihi_r   <= ihi_nxt;
      sb_mask_r  <= mask_nxt;
      sb_whole_r <= !overlap;
      sb_empty_r <= overlap && (slabs == '0);
    end
  end

  // piece emitter
  logic [SLAB_IDX_W-1:0] pick;
  logic [1:0]            pick_dim;
  slab_mask_t            rest_mask;
  coord_t                plo [3];
  coord_t                phi [3];

  always_comb begin
    pick = '0;
    for (int j = NUM_SLABS - 1; j >= 0; j--) begin
      if (sc_mask_r[j]) begin
        pick = SLAB_IDX_W'(j);
      end
    end
    pick_dim  = pick[2:1];
    rest_mask = sc_mask_r & ~(SLAB_FIRST << pick);
    pick_last = (rest_mask == '0);
    for (int k = 0; k < 3; k++) begin
      if (sc_whole_r) begin
        plo[k] = sc_alo_r[k];
        phi[k] = sc_ahi_r[k];
      end else if (sc_empty_r) begin
        plo[k] = '0;
        phi[k] = '0;
      end else if (2'(k) < pick_dim) begin
        plo[k] = sc_ilo_r[k];
        phi[k] = sc_ihi_r[k];
      end else if (2'(k) == pick_dim) begin
        plo[k] = pick[0] ? sc_ihi_r[k] : sc_alo_r[k];
        phi[k] = pick[0] ? sc_ahi_r[k] : sc_ilo_r[k];
      end else begin
        plo[k] = sc_alo_r[k];
        phi[k] = sc_ahi_r[k];
      end
    end
    if (c_take) begin
      sc_mask_nxt = sb_mask_r;
    end else if (out_load) begin
      sc_mask_nxt = rest_mask;
    end else begin
      sc_mask_nxt = sc_mask_r;
    end
  end

  always_ff @(posedge clk) begin
    sc_mask_r <= sc_mask_nxt;
    if (c_take) begin
      sc_alo_r   <= sb_alo_r;
      sc_ahi_r   <= sb_ahi_r;
      sc_ilo_r   <= sb_ilo_r;
      sc_ihi_r   <= sb_ihi_r;
      sc_whole_r <= sb_whole_r;
      sc_empty_r <= sb_empty_r;
    end
  end

  // output register
  coord_t out_lo_r [3];
  coord_t out_hi_r [3];
  logic   out_nothing_r, out_last_r;

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_lo_r      <= plo;
      out_hi_r      <= phi;
      out_nothing_r <= sc_empty_r;
      out_last_r    <= pick_last;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_piece_lo_x   = out_lo_r[0];
  assign out_piece_lo_y   = out_lo_r[1];
  assign out_piece_lo_z   = out_lo_r[2];
  assign out_piece_hi_x   = out_hi_r[0];
  assign out_piece_hi_y   = out_hi_r[1];
  assign out_piece_hi_z   = out_hi_r[2];
  assign out_nothing_left = out_nothing_r;
  assign out_last_piece   = out_last_r;

endmodule

>>> hdl/bmb_checker.sv
// ----------------------------------------------------------------------------
// bmb_checker
// port-level checks on the box difference splitter, bound to the top level
// ----------------------------------------------------------------------------
module bmb_checker #(
  parameter int COORD_BITS = 32
) (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_stall,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic signed [COORD_BITS-1:0] out_piece_lo_x,
  input logic signed [COORD_BITS-1:0] out_piece_lo_y,
  input logic signed [COORD_BITS-1:0] out_piece_lo_z,
  input logic signed [COORD_BITS-1:0] out_piece_hi_x,
  input logic signed [COORD_BITS-1:0] out_piece_hi_y,
  input logic signed [COORD_BITS-1:0] out_piece_hi_z,
  input logic                         out_nothing_left,
  input logic                         out_last_piece
);
  import bmb_pkg::*;

  logic       in_beat, out_beat;
  logic [2:0] piece_cnt_r;
  logic [2:0] pending_r;

  assign in_beat  = in_valid && !in_stall;
  assign out_beat = out_valid && !out_stall;

  // pieces sent so far for the current pair, and pairs taken but not finished
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      piece_cnt_r <= '0;
      pending_r   <= '0;
    end else begin
      if (out_beat) begin
        piece_cnt_r <= out_last_piece ? 3'd0 : piece_cnt_r + 3'd1;
      end
      pending_r <= pending_r + 3'(in_beat) - 3'(out_beat && out_last_piece);
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_piece_lo_x) && $stable(out_last_piece))
    else $error("result beat changed while stalled");

  a_empty_alone: assert property (@(posedge clk) disable iff (!rst_n)
    out_beat && out_nothing_left |-> out_last_piece && piece_cnt_r == 3'd0 &&
      out_piece_lo_x == '0 && out_piece_hi_x == '0 && out_piece_lo_y == '0 &&
      out_piece_hi_y == '0 && out_piece_lo_z == '0 && out_piece_hi_z == '0)
    else $error("empty result not a lone zero beat");

  a_six_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_beat && piece_cnt_r == 3'(NUM_SLABS - 1) |-> out_last_piece)
    else $error("more than six pieces for one pair");

  a_no_orphan: assert property (@(posedge clk) disable iff (!rst_n)
    out_beat |-> pending_r != 3'd0)
    else $error("result beat without an accepted pair");

endmodule

bind box_minus_box_splitter_core bmb_checker #(.COORD_BITS(COORD_BITS)) u_bmb_checker (.*);
